// ===== src/gmbr_pkg.sv =====
// ----------------------------------------------------------------------------
// gmbr_pkg
// Shared widths, register codes and item types for the grid path cost block.
// ----------------------------------------------------------------------------
package gmbr_pkg;

  localparam int MAX_ROWS   = 1024;
  localparam int MAX_COLS   = 1024;
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int COST_W     = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COST_W-1:0] COST_SAT = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1
  } cfg_reg_t;

  // Classified cell passed from the front to the back.
  typedef struct packed {
    logic             black;
    logic [COL_W-1:0] col;
    logic             has_up;
    logic             has_left;
    logic             first;
    logic             done;
  } cell_item_t;

  // One line buffer entry: cost and colour of the cell above.
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              colour;
  } line_entry_t;

endpackage

// ===== src/gmbr_front.sv =====
// ----------------------------------------------------------------------------
// gmbr_front
// Holds the grid size registers and the raster position; tags each cell.
// ----------------------------------------------------------------------------
module gmbr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [gmbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gmbr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          accept,
  input  logic                          cell_black,
  output gmbr_pkg::cell_item_t          item
);
  import gmbr_pkg::*;

  logic [ROW_W-1:0] row_last;
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_index;
  logic [COL_W-1:0] col_index;
  logic [ROW_W-1:0] row_last_next;
  logic [COL_W-1:0] col_last_next;
  logic             cfg_hit;
  logic             at_row_end;
  logic             at_col_end;

  // Clamp the written size to 1..MAX and keep it as a last index.
  always_comb begin
    if (cfg_data == '0) begin
      row_last_next = '0;
      col_last_next = '0;
    end else begin
      if (32'(cfg_data) > 32'(MAX_ROWS)) begin
        row_last_next = ROW_W'(MAX_ROWS - 1);
      end else begin
        row_last_next = ROW_W'(cfg_data - 1'b1);
      end
      if (32'(cfg_data) > 32'(MAX_COLS)) begin
        col_last_next = COL_W'(MAX_COLS - 1);
      end else begin
        col_last_next = COL_W'(cfg_data - 1'b1);
      end
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_GRID_ROWS: cfg_hit = cfg_valid;
      REG_GRID_COLS: cfg_hit = cfg_valid;
      default:       cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_last <= ROW_W'(MAX_ROWS - 1);
      col_last <= COL_W'(MAX_COLS - 1);
    end else if (cfg_valid && cfg_index == REG_GRID_ROWS) begin
      row_last <= row_last_next;
    end else if (cfg_valid && cfg_index == REG_GRID_COLS) begin
      col_last <= col_last_next;
    end
  end

  assign at_row_end = (row_index == row_last);
  assign at_col_end = (col_index == col_last);

  // Advance in raster order; wrap to the top-left after the last cell.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row_index <= '0;
      col_index <= '0;
    end else if (accept) begin
      if (at_col_end) begin
        col_index <= '0;
        row_index <= at_row_end ? '0 : row_index + 1'b1;
      end else begin
        col_index <= col_index + 1'b1;
      end
    end
  end

  always_comb begin
    item.black    = cell_black;
    item.col      = col_index;
    item.has_up   = (row_index != '0);
    item.has_left = (col_index != '0);
    item.first    = (row_index == '0) && (col_index == '0);
    item.done     = at_row_end && at_col_end;
  end

endmodule

// ===== src/gmbr_queue.sv =====
// ----------------------------------------------------------------------------
// gmbr_queue
// Short first-in first-out queue of tagged cells between front and back.
// ----------------------------------------------------------------------------
module gmbr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  gmbr_pkg::cell_item_t push_item,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output gmbr_pkg::cell_item_t head
);
  import gmbr_pkg::*;

  cell_item_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |-> !push)
    else $error("queue pushed while full");
`endif

endmodule

// ===== src/gmbr_back.sv =====
// ----------------------------------------------------------------------------
// gmbr_back
// Reads the line buffer, works out each cell's cost and holds the result.
// ----------------------------------------------------------------------------
module gmbr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  gmbr_pkg::cell_item_t          head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gmbr_pkg::COST_W-1:0]   path_cost,
  output logic                          grid_done
);
  import gmbr_pkg::*;

  line_entry_t line_mem [MAX_COLS];

  logic              b_valid;
  cell_item_t        b_item;
  line_entry_t       line_q;
  logic              fwd_hit;
  line_entry_t       fwd_data;
  logic [COST_W-1:0] left_cost;
  logic              left_colour;

  logic              out_free;
  logic              b_fire;
  line_entry_t       above;
  line_entry_t       wr_data;
  logic [COST_W:0]   up_sum;
  logic [COST_W:0]   left_sum;
  logic [COST_W:0]   best;
  logic [COST_W-1:0] cost;

  assign out_free = !out_valid || !out_stall;
  assign b_fire   = b_valid && out_free;
  assign pop      = head_valid && (!b_valid || b_fire);

  // Take the entry written at the same edge as the read from the bypass.
  assign above = fwd_hit ? fwd_data : line_q;

  always_comb begin
    up_sum   = {1'b0, above.cost} + (COST_W+1)'(b_item.black && !above.colour);
    left_sum = {1'b0, left_cost} + (COST_W+1)'(b_item.black && !left_colour);
    best     = '1;
    if (b_item.first) begin
      best = (COST_W+1)'(b_item.black);
    end else begin
      if (b_item.has_up && up_sum < best) begin
        best = up_sum;
      end
      if (b_item.has_left && left_sum < best) begin
        best = left_sum;
      end
    end
    cost = best[COST_W] ? COST_SAT : best[COST_W-1:0];
    wr_data.cost   = cost;
    wr_data.colour = b_item.black;
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      line_mem[b_item.col] <= wr_data;
    end
    if (pop) begin
      line_q <= line_mem[head.col];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_item   <= head;
      fwd_hit  <= b_fire && (b_item.col == head.col);
      fwd_data <= wr_data;
    end
    if (b_fire) begin
      left_cost   <= cost;
      left_colour <= b_item.black;
      path_cost   <= cost;
      grid_done   <= b_item.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_fire_fills_output: assert property (@(posedge clk) disable iff (rst)
    b_fire |=> out_valid)
    else $error("computed request did not reach the output register");

  a_held_stage_stays: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_fire) |=> (b_valid && $stable(b_item)))
    else $error("stalled compute stage changed");
`endif

endmodule

// ===== src/grid_min_black_runs_path_dp.sv =====
// ----------------------------------------------------------------------------
// grid_min_black_runs_path_dp
// Fewest black runs over right/down grid paths, one cell per request.
// ----------------------------------------------------------------------------
// Feed the grid one cell per request in raster order (cell_black: 1 black,
// 0 white). For every cell the block returns path_cost, the fewest black
// runs along any right/down path from the top-left cell to that cell,
// saturating at 2047; grid_done marks the bottom-right cell, whose cost is
// the answer for the whole grid, after which the next cell starts a new
// grid. Rate: one cell per clock sustained while out_stall is low, set by
// the line buffer that holds the row above, which takes one read and one
// write a cycle. A request passes from the queue into the compute stage,
// which holds the line buffer read, and then into the output register.
// Write grid_rows (index 0) and grid_cols (index 1) only while the block
// is idle; a write clamps the size to 1..1024 and restarts the grid.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module grid_min_black_runs_path_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cell_black,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gmbr_pkg::COST_W-1:0]   path_cost,
  output logic                          grid_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gmbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gmbr_pkg::CFG_W-1:0]     cfg_data
);
  import gmbr_pkg::*;

  logic       accept;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;
  cell_item_t front_item;
  cell_item_t q_head;

  // Hold off new requests only when the queue is full.
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign cfg_ready = 1'b1;

  gmbr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .cell_black (cell_black),
    .item       (front_item)
  );

  gmbr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (front_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  gmbr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_not_empty),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .path_cost  (path_cost),
    .grid_done  (grid_done)
  );

endmodule
